FILE: rtl/core/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared widths, codes and control/status structs of the contact pair tracker.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int FLAG_BITS   = 16;

    localparam int ID_W   = 32;
    localparam int FLAG_W = 16;
    localparam int KIND_W = 2;
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // item commands
    localparam logic CMD_COLLISION = 1'b0;
    localparam logic CMD_TICK      = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] EVT_STARTED  = 2'd0;
    localparam logic [KIND_W-1:0] EVT_FINISHED = 2'd1;
    localparam logic [KIND_W-1:0] EVT_FULL     = 2'd2;

    typedef struct packed {
        logic load_item;
        logic col_exec;
        logic tick_step;
        logic tick_finish;
    } cpt_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic item_ok;
        logic hit;
        logic slot_free;
        logic sweep_done;
        logic rd_stale;
    } cpt_status_t;

    // only the low FLAG_BITS of the flag fields take part
    function automatic logic [FLAG_W-1:0] flag_mask();
        logic [FLAG_W-1:0] m;
        m = '0;
        for (int i = 0; i < FLAG_W; i++)
        begin
            m[i] = (i < FLAG_BITS);
        end
        return m;
    endfunction

endpackage

FILE: rtl/core/cpt_if.sv
// ----------------------------------------------------------------------------
// cpt_in_if / cpt_out_if
// Valid/ready channels for collision and tick items and for contact events.
// ----------------------------------------------------------------------------
interface cpt_in_if
    import cpt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ID_W-1:0]   entity_first;
    logic [ID_W-1:0]   entity_second;
    logic              both_interactable;
    logic [FLAG_W-1:0] type_first;
    logic [FLAG_W-1:0] accept_first;
    logic [FLAG_W-1:0] type_second;
    logic [FLAG_W-1:0] accept_second;

    modport source (
        output valid, cmd, entity_first, entity_second, both_interactable,
               type_first, accept_first, type_second, accept_second,
        input  ready
    );
    modport sink (
        input  valid, cmd, entity_first, entity_second, both_interactable,
               type_first, accept_first, type_second, accept_second,
        output ready
    );
endinterface

interface cpt_out_if
    import cpt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [ID_W-1:0]   event_first;
    logic [ID_W-1:0]   event_second;
    logic              last_result;

    modport source (
        output valid, event_kind, event_first, event_second, last_result,
        input  ready
    );
    modport sink (
        input  valid, event_kind, event_first, event_second, last_result,
        output ready
    );
endinterface

FILE: rtl/core/contact_pair_tracker_unit.sv
// ----------------------------------------------------------------------------
// contact_pair_tracker_unit
// Contact pair table: reports started, finished and table-full events.
// ----------------------------------------------------------------------------
// collision item: accepted, matched against all live cells the next cycle, event
//   registered once the event register is free; no new item is taken until it is done
// tick item: the sweep visits one cell per cycle unless a finished event waits
//   for the event register, and emits at most one finished item per cycle
// reset clears the pair count, stale marks and event valid; no clearing pass
module contact_pair_tracker_unit
    import cpt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cpt_in_if.sink    items,
    cpt_out_if.source events
);

    cpt_cmd_t    cmd;
    cpt_status_t status;
    logic        ctrl_ready;

    assign items.ready = ctrl_ready;

    cpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (ctrl_ready),
        .status   (status),
        .cmd      (cmd)
    );

    cpt_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items),
        .events (events),
        .cmd    (cmd),
        .status (status)
    );

endmodule

FILE: rtl/core/cpt_ctrl.sv
// ----------------------------------------------------------------------------
// cpt_ctrl
// Sequencer: takes one item, runs the lookup or the table sweep, issues
// datapath commands.
// ----------------------------------------------------------------------------
module cpt_ctrl
    import cpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  cpt_status_t status,
    output cpt_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SWEEP
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (status.is_tick)
                begin
                    state_next = ST_SWEEP;
                end
                else if (!status.item_ok)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.hit || status.slot_free)
                begin
                    cmd.col_exec = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (status.sweep_done)
                begin
                    cmd.tick_finish = 1'b1;
                    state_next      = ST_IDLE;
                end
                else if (!status.rd_stale || status.slot_free)
                begin
                    cmd.tick_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/cpt_datapath.sv
// ----------------------------------------------------------------------------
// cpt_datapath
// Pair table cells with parallel match, sweep pointers and the event register.
// ----------------------------------------------------------------------------
module cpt_datapath
    import cpt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cpt_in_if.sink      items,
    cpt_out_if.source   events,
    input  cpt_cmd_t    cmd,
    output cpt_status_t status
);

    logic                 is_tick_reg;
    logic                 item_ok_reg;
    logic [ID_W-1:0]      a_reg;
    logic [ID_W-1:0]      b_reg;

    logic [ID_W-1:0]      first_reg  [TABLE_DEPTH];
    logic [ID_W-1:0]      second_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] stale_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     rd_reg;
    logic [CNT_W-1:0]     wr_reg;

    logic                 out_valid_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic [ID_W-1:0]      out_first_reg;
    logic [ID_W-1:0]      out_second_reg;
    logic                 out_last_reg;

    logic [FLAG_W-1:0]    fm;
    logic                 item_ok;
    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [TABLE_DEPTH-1:0] above_vec;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     wr_idx;
    logic [IDX_W-1:0]     ins_idx;
    logic                 hit;
    logic                 full;
    logic                 rd_stale;
    logic                 more_stale;
    logic                 col_emit;
    logic                 col_insert;
    logic                 tick_emit;
    logic                 tick_move;

    assign fm = flag_mask();
    assign item_ok = items.both_interactable
                     && ((items.accept_first & items.type_second & fm) != '0)
                     && ((items.accept_second & items.type_first & fm) != '0);

    // all live cells compare against the pair in both orders at once
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            valid_vec[i] = (CNT_W'(i) < count_reg);
            above_vec[i] = valid_vec[i] && (CNT_W'(i) > rd_reg);
            hit_vec[i]   = valid_vec[i]
                           && (((first_reg[i] == a_reg) && (second_reg[i] == b_reg))
                               || ((first_reg[i] == b_reg) && (second_reg[i] == a_reg)));
        end
    end

    assign rd_idx     = rd_reg[IDX_W-1:0];
    assign wr_idx     = wr_reg[IDX_W-1:0];
    assign ins_idx    = count_reg[IDX_W-1:0];
    assign hit        = |hit_vec;
    assign full       = (count_reg == CNT_W'(TABLE_DEPTH));
    assign rd_stale   = stale_reg[rd_idx];
    assign more_stale = |(stale_reg & above_vec);

    assign col_emit   = cmd.col_exec && !hit;
    assign col_insert = col_emit && !full;
    assign tick_emit  = cmd.tick_step && rd_stale;
    assign tick_move  = cmd.tick_step && !rd_stale;

    assign status.is_tick    = is_tick_reg;
    assign status.item_ok    = item_ok_reg;
    assign status.hit        = hit;
    assign status.slot_free  = !out_valid_reg || events.ready;
    assign status.sweep_done = (rd_reg >= count_reg);
    assign status.rd_stale   = rd_stale;

    assign events.valid        = out_valid_reg;
    assign events.event_kind   = out_kind_reg;
    assign events.event_first  = out_first_reg;
    assign events.event_second = out_second_reg;
    assign events.last_result  = out_last_reg;

    // item capture and cell contents
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            is_tick_reg <= (items.cmd == CMD_TICK);
            item_ok_reg <= item_ok;
            a_reg       <= items.entity_first;
            b_reg       <= items.entity_second;
        end
        if (col_insert)
        begin
            first_reg[ins_idx]  <= a_reg;
            second_reg[ins_idx] <= b_reg;
        end
        else if (tick_move)
        begin
            first_reg[wr_idx]  <= first_reg[rd_idx];
            second_reg[wr_idx] <= second_reg[rd_idx];
        end
    end

    // stale marks, fill count and sweep pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg <= '0;
            count_reg <= '0;
            rd_reg    <= '0;
            wr_reg    <= '0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                rd_reg <= '0;
                wr_reg <= '0;
            end
            if (cmd.col_exec)
            begin
                // an insert is always a miss, so no hit mark to clear then
                if (col_insert)
                begin
                    stale_reg[ins_idx] <= 1'b0;
                    count_reg          <= count_reg + CNT_W'(1);
                end
                else
                begin
                    stale_reg <= stale_reg & ~hit_vec;
                end
            end
            if (cmd.tick_step)
            begin
                rd_reg <= rd_reg + CNT_W'(1);
            end
            if (tick_move)
            begin
                stale_reg[wr_idx] <= 1'b1;
                wr_reg            <= wr_reg + CNT_W'(1);
            end
            if (cmd.tick_finish)
            begin
                count_reg <= wr_reg;
            end
        end
    end

    // event register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (col_emit || tick_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (events.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_emit)
        begin
            out_kind_reg   <= full ? EVT_FULL : EVT_STARTED;
            out_first_reg  <= a_reg;
            out_second_reg <= b_reg;
            out_last_reg   <= 1'b1;
        end
        else if (tick_emit)
        begin
            out_kind_reg   <= EVT_FINISHED;
            out_first_reg  <= first_reg[rd_idx];
            out_second_reg <= second_reg[rd_idx];
            out_last_reg   <= !more_stale;
        end
    end

endmodule

FILE: rtl/core/cpt_checker.sv
// ----------------------------------------------------------------------------
// cpt_checker
// Port-level checks of the contact pair tracker, bound to the top level.
// ----------------------------------------------------------------------------
module cpt_checker
    import cpt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [KIND_W-1:0] event_kind,
    input logic [ID_W-1:0]   event_first,
    input logic [ID_W-1:0]   event_second,
    input logic              last_result
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind)
            && $stable(event_first) && $stable(event_second) && $stable(last_result))
        else $error("stalled event item changed");

    // one item at a time: no second item right after an accepted one
    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item in progress");

    // a collision causes at most a single result, flagged last
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind != EVT_FINISHED) |-> last_result)
        else $error("started or full event not flagged last");

    // no undefined kind code
    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_kind == EVT_STARTED) || (event_kind == EVT_FINISHED)
            || (event_kind == EVT_FULL))
        else $error("event kind out of range");

endmodule

bind contact_pair_tracker_unit cpt_checker u_cpt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (items.valid),
    .in_ready     (items.ready),
    .out_valid    (events.valid),
    .out_ready    (events.ready),
    .event_kind   (events.event_kind),
    .event_first  (events.event_first),
    .event_second (events.event_second),
    .last_result  (events.last_result)
);

FILE: dv/contact_pair_tracker_unit_check.sv
// ----------------------------------------------------------------------------
// contact_pair_tracker_unit_check
// Watches the item and event channels, keeps its own contact pair table and
// compares every event leaving the block with the oldest one it predicted.
// ----------------------------------------------------------------------------
module contact_pair_tracker_unit_check
    import cpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cpt_in_if    items,
    cpt_out_if   events,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   first;
        logic [ID_W-1:0]   second;
        logic              last;
    } contact_event_t;

    localparam int KEEP_N = (FLAG_BITS < FLAG_W) ? FLAG_BITS : FLAG_W;
    localparam logic [FLAG_W-1:0] FLAG_KEEP = {FLAG_W{1'b1}} >> (FLAG_W - KEEP_N);

    logic [ID_W-1:0] pair_first  [TABLE_DEPTH];
    logic [ID_W-1:0] pair_second [TABLE_DEPTH];
    logic            pair_stale  [TABLE_DEPTH];
    int              pair_count;

    contact_event_t  expected_events[$];
    contact_event_t  want;
    int              errors = 0;

    assign fail_count = errors;

    function automatic contact_event_t make_event(logic [KIND_W-1:0] kind,
                                                  logic [ID_W-1:0] first,
                                                  logic [ID_W-1:0] second,
                                                  logic last);
        contact_event_t e;
        e.kind   = kind;
        e.first  = first;
        e.second = second;
        e.last   = last;
        return e;
    endfunction

    function automatic void add_expected(contact_event_t e);
        expected_events.insert(expected_events.size(), e);
    endfunction

    task automatic track_collision(logic [ID_W-1:0] a, logic [ID_W-1:0] b, logic inter,
                                   logic [FLAG_W-1:0] ta, logic [FLAG_W-1:0] ma,
                                   logic [FLAG_W-1:0] tb, logic [FLAG_W-1:0] mb);
        if (!inter)
        begin
            return;
        end
        if ((ma & tb & FLAG_KEEP) == '0 || (mb & ta & FLAG_KEEP) == '0)
        begin
            return;
        end
        // unordered lookup, a hit only refreshes the pair
        for (int i = 0; i < pair_count; i++)
        begin
            if ((pair_first[i] == a && pair_second[i] == b) ||
                (pair_first[i] == b && pair_second[i] == a))
            begin
                pair_stale[i] = 1'b0;
                return;
            end
        end
        if (pair_count >= TABLE_DEPTH)
        begin
            add_expected(make_event(EVT_FULL, a, b, 1'b1));
            return;
        end
        pair_first[pair_count]  = a;
        pair_second[pair_count] = b;
        pair_stale[pair_count]  = 1'b0;
        pair_count++;
        add_expected(make_event(EVT_STARTED, a, b, 1'b1));
    endtask

    task automatic sweep_tick();
        int kept;
        int base;
        kept = 0;
        base = expected_events.size();
        for (int rd = 0; rd < pair_count; rd++)
        begin
            if (pair_stale[rd])
            begin
                add_expected(
                    make_event(EVT_FINISHED, pair_first[rd], pair_second[rd], 1'b0));
            end
            else
            begin
                pair_first[kept]  = pair_first[rd];
                pair_second[kept] = pair_second[rd];
                pair_stale[kept]  = 1'b1;
                kept++;
            end
        end
        pair_count = kept;
        if (expected_events.size() > base)
        begin
            expected_events[expected_events.size() - 1].last = 1'b1;
        end
    endtask

    task automatic check_field(string name, logic [ID_W-1:0] exp_val,
                               logic [ID_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            errors++;
            $display("%0t: event %s mismatch, expected %h, actual %h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pair_count = 0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                pair_stale[i] = 1'b0;
            end
            expected_events.delete();
        end
        else
        begin
            // events leaving now belong to items taken at earlier edges
            if (events.valid && events.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected event, expected none, actual kind %0d %h %h last %b",
                             $time, events.event_kind, events.event_first,
                             events.event_second, events.last_result);
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("kind", ID_W'(want.kind), ID_W'(events.event_kind));
                    check_field("first", want.first, events.event_first);
                    check_field("second", want.second, events.event_second);
                    check_field("last", ID_W'(want.last), ID_W'(events.last_result));
                end
            end
            if (items.valid && items.ready)
            begin
                if (items.cmd == CMD_TICK)
                begin
                    sweep_tick();
                end
                else
                begin
                    track_collision(items.entity_first, items.entity_second,
                                    items.both_interactable,
                                    items.type_first, items.accept_first,
                                    items.type_second, items.accept_second);
                end
            end
        end
        pending <= expected_events.size();
    end

endmodule

FILE: dv/contact_pair_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// contact_pair_tracker_unit_tb
// Drives collision and tick items into the contact pair tracker with random
// gaps and output stalls; a directed opening covers rejects, reversed and
// self pairs, sweeps and a full table, then random contact bursts follow.
// ----------------------------------------------------------------------------
module contact_pair_tracker_unit_tb;
    import cpt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_N    = 10;
    localparam int RANDOM_N  = 200;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_events;

    cpt_in_if  items();
    cpt_out_if events();

    contact_pair_tracker_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items),
        .events (events)
    );

    contact_pair_tracker_unit_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .events     (events),
        .fail_count (fail_count),
        .pending    (pending_events)
    );

    logic [ID_W-1:0] id_pool[POOL_N];
    bit              no_idle;
    int              scored;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    task automatic send_item(logic cmd, logic [ID_W-1:0] a, logic [ID_W-1:0] b,
                             logic inter, logic [FLAG_W-1:0] ta, logic [FLAG_W-1:0] ma,
                             logic [FLAG_W-1:0] tb, logic [FLAG_W-1:0] mb);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            items.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        items.valid             <= 1'b1;
        items.cmd               <= cmd;
        items.entity_first      <= a;
        items.entity_second     <= b;
        items.both_interactable <= inter;
        items.type_first        <= ta;
        items.accept_first      <= ma;
        items.type_second       <= tb;
        items.accept_second     <= mb;
        do
            @(posedge clk);
        while (items.ready !== 1'b1);
    endtask

    task automatic send_tick();
        send_item(CMD_TICK, $urandom, $urandom, 1'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // flags that let both sides accept each other, sparse or dense
    task automatic send_contact(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        logic [FLAG_W-1:0] hit_ab;
        logic [FLAG_W-1:0] hit_ba;
        hit_ab = FLAG_W'(1) << $urandom_range(0, FLAG_BITS - 1);
        hit_ba = FLAG_W'(1) << $urandom_range(0, FLAG_BITS - 1);
        if ($urandom_range(0, 1) == 0)
        begin
            send_item(CMD_COLLISION, a, b, 1'b1, hit_ba, hit_ab, hit_ab, hit_ba);
        end
        else
        begin
            send_item(CMD_COLLISION, a, b, 1'b1,
                      16'($urandom) | hit_ba, 16'($urandom) | hit_ab,
                      16'($urandom) | hit_ab, 16'($urandom) | hit_ba);
        end
    endtask

    task automatic send_noise();
        logic [FLAG_W-1:0] t;
        t = 16'($urandom);
        case ($urandom_range(0, 3))
            0: send_item(CMD_COLLISION, id_pool[$urandom_range(0, POOL_N - 1)],
                         id_pool[$urandom_range(0, POOL_N - 1)], 1'b0,
                         16'hffff, 16'hffff, 16'hffff, 16'hffff);
            1: send_item(CMD_COLLISION, $urandom, $urandom, 1'b1,
                         16'($urandom), ~t, t, 16'($urandom));
            2: send_item(CMD_COLLISION, $urandom, $urandom, 1'b1,
                         t, 16'($urandom), 16'($urandom), ~t);
            default: send_item(CMD_COLLISION, $urandom, $urandom, 1'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        endcase
    endtask

    // sink side: runs of ready with stalls of random length between
    initial
    begin
        int unsigned n;
        events.ready = 1'b0;
        forever
        begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            repeat (n)
            begin
                @(negedge clk);
                events.ready <= 1'b1;
            end
            n = pick_gap();
            repeat (n)
            begin
                @(negedge clk);
                events.ready <= 1'b0;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("[contact_pair_tracker_unit] ERROR");
        $finish;
    end

    initial
    begin
        int unsigned burst;
        rst_n                   = 1'b0;
        items.valid             = 1'b0;
        items.cmd               = CMD_COLLISION;
        items.entity_first      = '0;
        items.entity_second     = '0;
        items.both_interactable = 1'b0;
        items.type_first        = '0;
        items.accept_first      = '0;
        items.type_second       = '0;
        items.accept_second     = '0;
        no_idle                 = 1'b0;
        scored                  = 0;
        id_pool[0]              = '0;
        id_pool[1]              = '1;
        for (int i = 2; i < POOL_N; i++)
        begin
            id_pool[i] = $urandom;
        end
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // directed opening
        send_tick();
        send_item(CMD_COLLISION, '0, '1, 1'b0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_item(CMD_COLLISION, 32'd1, 32'd2, 1'b1, 16'h0001, 16'h0002, 16'h0004, 16'h0001);
        send_item(CMD_COLLISION, 32'd1, 32'd2, 1'b1, 16'h0001, 16'h0004, 16'h0004, 16'h0002);
        send_item(CMD_COLLISION, '0, '1, 1'b1, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_item(CMD_COLLISION, '1, '0, 1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_contact(32'h5a5a_a5a5, 32'h5a5a_a5a5);
        send_tick();
        send_contact('0, '1);
        send_tick();
        send_tick();
        // fill the table, then one more pair is dropped
        for (int i = 0; i <= TABLE_DEPTH; i++)
        begin
            send_contact(32'h8000_0000 | i, ~(32'h0000_1000 + i));
        end
        send_tick();
        send_tick();

        // random contact traffic
        while (scored < RANDOM_N)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            id_pool[$urandom_range(2, POOL_N - 1)] = $urandom;
            case ($urandom_range(0, 9))
                0:
                begin
                    burst = $urandom_range(8, 20);
                    repeat (burst) send_contact($urandom, $urandom);
                    scored += burst;
                end
                1:
                begin
                    repeat ($urandom_range(1, 4)) send_noise();
                end
                default:
                begin
                    burst = $urandom_range(3, 12);
                    repeat (burst)
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            send_tick();
                        end
                        else
                        begin
                            send_contact(id_pool[$urandom_range(0, POOL_N - 1)],
                                         id_pool[$urandom_range(0, POOL_N - 1)]);
                        end
                    end
                    send_tick();
                    scored += burst + 1;
                end
            endcase
        end
        @(negedge clk);
        items.valid <= 1'b0;

        while (pending_events != 0)
        begin
            @(posedge clk);
        end
        // a sweep with nothing stale may still be running
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[contact_pair_tracker_unit] OK");
        end
        else
        begin
            $display("[contact_pair_tracker_unit] ERROR");
        end
        $finish;
    end

endmodule
